### rtl/core/cmg_pkg.sv
// ----------------------------------------------------------------------------
// cmg_pkg - shared types and constants of the chaotic map generator
// Fixed-point formats, micro-op encoding, per-map programs, CORDIC table.
// ----------------------------------------------------------------------------
`default_nettype none

package cmg_pkg;

  // Field and state widths
  localparam int unsigned STATE_W   = 32;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned PHASE_W   = 32;
  localparam int unsigned FRAC_W    = 24;
  localparam int unsigned COEF_FRAC = 11;
  localparam int unsigned TMP_N     = 8;

  localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S_ONE = 32'sh0100_0000;

  // Angle constants in Q2.30
  localparam logic signed [39:0] TWO_PI30  = 40'sd6746518852;
  localparam logic signed [39:0] PI30      = 40'sd3373259426;
  localparam logic signed [39:0] HALF_PI30 = 40'sd1686629713;
  localparam logic signed [33:0] CORDIC_K  = 34'sd652032874;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MAP_SEL   = 3'd0,
    CFG_EXT_CLK   = 3'd1,
    CFG_LATCH_STP = 3'd2,
    CFG_ITER_STP  = 3'd3,
    CFG_TRIG_HI   = 3'd4,
    CFG_TRIG_LO   = 3'd5
  } cfg_idx_e;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_CADD, OP_MUL, OP_DIV, OP_SQRT, OP_SIN, OP_COS
  } op_e;

  // Operand and destination codes
  typedef enum logic [3:0] {
    R_X, R_Y, R_A, R_B, R_C, R_D, R_ONE, R_ZERO,
    R_T0, R_T1, R_T2, R_T3, R_T4, R_T5, R_T6, R_T7
  } reg_e;

  typedef struct packed {
    op_e  op;
    reg_e dst;
    reg_e sa;
    reg_e sb;
    logic last;
  } uop_t;

  typedef enum logic [1:0] {CS_IDLE, CS_FETCH, CS_EXEC, CS_WAIT} ctrl_state_e;

  typedef enum logic [3:0] {
    UP_IDLE, UP_MUL, UP_DIV, UP_DIVOUT, UP_SQRT,
    UP_RED, UP_FOLD1, UP_FOLD2, UP_ROT, UP_CFIN
  } unit_phase_e;

  typedef struct packed {
    logic item;
    logic fetch;
    logic start;
    uop_t uop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       wrap;
    logic       done;
    logic       unit_busy;
    logic [2:0] active_map;
  } dp_status_t;

  function automatic uop_t mk(op_e op, reg_e d, reg_e a, reg_e b, logic last);
    uop_t u;
    u.op = op; u.dst = d; u.sa = a; u.sb = b; u.last = last;
    return u;
  endfunction

  // Micro-programs, one per map; the last two ops commit x and y
  function automatic uop_t prog_rom(logic [2:0] map, logic [4:0] pc);
    uop_t u;
    u = mk(OP_ADD, R_ZERO, R_ZERO, R_ZERO, 1'b1);
    case (map)
      3'd0: begin // Clifford
        case (pc)
          5'd0:  u = mk(OP_MUL, R_T0, R_A, R_Y, 1'b0);
          5'd1:  u = mk(OP_SIN, R_T0, R_T0, R_ZERO, 1'b0);
          5'd2:  u = mk(OP_MUL, R_T1, R_A, R_X, 1'b0);
          5'd3:  u = mk(OP_COS, R_T1, R_T1, R_ZERO, 1'b0);
          5'd4:  u = mk(OP_MUL, R_T1, R_C, R_T1, 1'b0);
          5'd5:  u = mk(OP_ADD, R_T0, R_T0, R_T1, 1'b0);
          5'd6:  u = mk(OP_MUL, R_T1, R_B, R_X, 1'b0);
          5'd7:  u = mk(OP_SIN, R_T1, R_T1, R_ZERO, 1'b0);
          5'd8:  u = mk(OP_MUL, R_T2, R_B, R_Y, 1'b0);
          5'd9:  u = mk(OP_COS, R_T2, R_T2, R_ZERO, 1'b0);
          5'd10: u = mk(OP_MUL, R_T2, R_D, R_T2, 1'b0);
          5'd11: u = mk(OP_ADD, R_T1, R_T1, R_T2, 1'b0);
          5'd12: u = mk(OP_ADD, R_X, R_T0, R_ZERO, 1'b0);
          5'd13: u = mk(OP_ADD, R_Y, R_T1, R_ZERO, 1'b1);
          default: ;
        endcase
      end
      3'd1: begin // De Jong
        case (pc)
          5'd0:  u = mk(OP_MUL, R_T0, R_A, R_Y, 1'b0);
          5'd1:  u = mk(OP_SIN, R_T0, R_T0, R_ZERO, 1'b0);
          5'd2:  u = mk(OP_MUL, R_T1, R_B, R_X, 1'b0);
          5'd3:  u = mk(OP_COS, R_T1, R_T1, R_ZERO, 1'b0);
          5'd4:  u = mk(OP_SUB, R_T0, R_T0, R_T1, 1'b0);
          5'd5:  u = mk(OP_MUL, R_T1, R_C, R_X, 1'b0);
          5'd6:  u = mk(OP_SIN, R_T1, R_T1, R_ZERO, 1'b0);
          5'd7:  u = mk(OP_MUL, R_T2, R_D, R_Y, 1'b0);
          5'd8:  u = mk(OP_COS, R_T2, R_T2, R_ZERO, 1'b0);
          5'd9:  u = mk(OP_SUB, R_T1, R_T1, R_T2, 1'b0);
          5'd10: u = mk(OP_ADD, R_X, R_T0, R_ZERO, 1'b0);
          5'd11: u = mk(OP_ADD, R_Y, R_T1, R_ZERO, 1'b1);
          default: ;
        endcase
      end
      3'd2: begin // Svensson
        case (pc)
          5'd0:  u = mk(OP_MUL, R_T0, R_A, R_X, 1'b0);
          5'd1:  u = mk(OP_SIN, R_T1, R_T0, R_ZERO, 1'b0);
          5'd2:  u = mk(OP_MUL, R_T1, R_D, R_T1, 1'b0);
          5'd3:  u = mk(OP_MUL, R_T2, R_B, R_Y, 1'b0);
          5'd4:  u = mk(OP_SIN, R_T3, R_T2, R_ZERO, 1'b0);
          5'd5:  u = mk(OP_SUB, R_T1, R_T1, R_T3, 1'b0);
          5'd6:  u = mk(OP_COS, R_T0, R_T0, R_ZERO, 1'b0);
          5'd7:  u = mk(OP_MUL, R_T0, R_C, R_T0, 1'b0);
          5'd8:  u = mk(OP_COS, R_T2, R_T2, R_ZERO, 1'b0);
          5'd9:  u = mk(OP_ADD, R_T0, R_T0, R_T2, 1'b0);
          5'd10: u = mk(OP_ADD, R_X, R_T1, R_ZERO, 1'b0);
          5'd11: u = mk(OP_ADD, R_Y, R_T0, R_ZERO, 1'b1);
          default: ;
        endcase
      end
      3'd3: begin // Bedhead
        case (pc)
          5'd0:  u = mk(OP_MUL, R_T0, R_X, R_Y, 1'b0);
          5'd1:  u = mk(OP_DIV, R_T0, R_T0, R_B, 1'b0);
          5'd2:  u = mk(OP_SIN, R_T0, R_T0, R_ZERO, 1'b0);
          5'd3:  u = mk(OP_MUL, R_T0, R_T0, R_Y, 1'b0);
          5'd4:  u = mk(OP_MUL, R_T1, R_A, R_X, 1'b0);
          5'd5:  u = mk(OP_SUB, R_T1, R_T1, R_Y, 1'b0);
          5'd6:  u = mk(OP_COS, R_T1, R_T1, R_ZERO, 1'b0);
          5'd7:  u = mk(OP_ADD, R_T0, R_T0, R_T1, 1'b0);
          5'd8:  u = mk(OP_SIN, R_T1, R_Y, R_ZERO, 1'b0);
          5'd9:  u = mk(OP_DIV, R_T1, R_T1, R_B, 1'b0);
          5'd10: u = mk(OP_ADD, R_T1, R_X, R_T1, 1'b0);
          5'd11: u = mk(OP_ADD, R_X, R_T0, R_ZERO, 1'b0);
          5'd12: u = mk(OP_ADD, R_Y, R_T1, R_ZERO, 1'b1);
          default: ;
        endcase
      end
      3'd4: begin // Dream
        case (pc)
          5'd0:  u = mk(OP_MUL, R_T0, R_Y, R_B, 1'b0);
          5'd1:  u = mk(OP_SIN, R_T0, R_T0, R_ZERO, 1'b0);
          5'd2:  u = mk(OP_MUL, R_T1, R_X, R_B, 1'b0);
          5'd3:  u = mk(OP_SIN, R_T1, R_T1, R_ZERO, 1'b0);
          5'd4:  u = mk(OP_MUL, R_T1, R_C, R_T1, 1'b0);
          5'd5:  u = mk(OP_ADD, R_T0, R_T0, R_T1, 1'b0);
          5'd6:  u = mk(OP_MUL, R_T1, R_X, R_A, 1'b0);
          5'd7:  u = mk(OP_SIN, R_T1, R_T1, R_ZERO, 1'b0);
          5'd8:  u = mk(OP_MUL, R_T2, R_Y, R_A, 1'b0);
          5'd9:  u = mk(OP_SIN, R_T2, R_T2, R_ZERO, 1'b0);
          5'd10: u = mk(OP_MUL, R_T2, R_D, R_T2, 1'b0);
          5'd11: u = mk(OP_ADD, R_T1, R_T1, R_T2, 1'b0);
          5'd12: u = mk(OP_ADD, R_X, R_T0, R_ZERO, 1'b0);
          5'd13: u = mk(OP_ADD, R_Y, R_T1, R_ZERO, 1'b1);
          default: ;
        endcase
      end
      3'd5: begin // Hopalong A
        case (pc)
          5'd0:  u = mk(OP_MUL, R_T0, R_B, R_X, 1'b0);
          5'd1:  u = mk(OP_SUB, R_T0, R_T0, R_C, 1'b0);
          5'd2:  u = mk(OP_SQRT, R_T0, R_T0, R_ZERO, 1'b0);
          5'd3:  u = mk(OP_CADD, R_T0, R_Y, R_T0, 1'b0);
          5'd4:  u = mk(OP_SUB, R_T1, R_A, R_X, 1'b0);
          5'd5:  u = mk(OP_ADD, R_X, R_T0, R_ZERO, 1'b0);
          5'd6:  u = mk(OP_ADD, R_Y, R_T1, R_ZERO, 1'b1);
          default: ;
        endcase
      end
      3'd6: begin // Hopalong B
        case (pc)
          5'd0:  u = mk(OP_MUL, R_T0, R_B, R_X, 1'b0);
          5'd1:  u = mk(OP_SUB, R_T0, R_T0, R_ONE, 1'b0);
          5'd2:  u = mk(OP_SUB, R_T0, R_T0, R_C, 1'b0);
          5'd3:  u = mk(OP_SQRT, R_T0, R_T0, R_ZERO, 1'b0);
          5'd4:  u = mk(OP_SUB, R_T1, R_Y, R_ONE, 1'b0);
          5'd5:  u = mk(OP_CADD, R_T0, R_T1, R_T0, 1'b0);
          5'd6:  u = mk(OP_SUB, R_T1, R_A, R_X, 1'b0);
          5'd7:  u = mk(OP_SUB, R_T1, R_T1, R_ONE, 1'b0);
          5'd8:  u = mk(OP_ADD, R_X, R_T0, R_ZERO, 1'b0);
          5'd9:  u = mk(OP_ADD, R_Y, R_T1, R_ZERO, 1'b1);
          default: ;
        endcase
      end
      default: begin // Gumowski-Mira
        case (pc)
          5'd0:  u = mk(OP_MUL, R_T0, R_Y, R_Y, 1'b0);
          5'd1:  u = mk(OP_MUL, R_T0, R_B, R_T0, 1'b0);
          5'd2:  u = mk(OP_SUB, R_T0, R_ONE, R_T0, 1'b0);
          5'd3:  u = mk(OP_MUL, R_T0, R_A, R_T0, 1'b0);
          5'd4:  u = mk(OP_MUL, R_T0, R_T0, R_Y, 1'b0);
          5'd5:  u = mk(OP_ADD, R_T0, R_Y, R_T0, 1'b0);
          5'd6:  u = mk(OP_MUL, R_T1, R_X, R_X, 1'b0);
          5'd7:  u = mk(OP_SUB, R_T2, R_ONE, R_C, 1'b0);
          5'd8:  u = mk(OP_ADD, R_T2, R_T2, R_T2, 1'b0);
          5'd9:  u = mk(OP_MUL, R_T2, R_T2, R_T1, 1'b0);
          5'd10: u = mk(OP_ADD, R_T1, R_ONE, R_T1, 1'b0);
          5'd11: u = mk(OP_DIV, R_T2, R_T2, R_T1, 1'b0);
          5'd12: u = mk(OP_MUL, R_T1, R_C, R_X, 1'b0);
          5'd13: u = mk(OP_ADD, R_T1, R_T1, R_T2, 1'b0);
          5'd14: u = mk(OP_ADD, R_T0, R_T0, R_T1, 1'b0);
          5'd15: u = mk(OP_MUL, R_T1, R_T0, R_T0, 1'b0);
          5'd16: u = mk(OP_SUB, R_T2, R_ONE, R_C, 1'b0);
          5'd17: u = mk(OP_ADD, R_T2, R_T2, R_T2, 1'b0);
          5'd18: u = mk(OP_MUL, R_T2, R_T2, R_T1, 1'b0);
          5'd19: u = mk(OP_ADD, R_T1, R_ONE, R_T1, 1'b0);
          5'd20: u = mk(OP_DIV, R_T2, R_T2, R_T1, 1'b0);
          5'd21: u = mk(OP_MUL, R_T1, R_C, R_T0, 1'b0);
          5'd22: u = mk(OP_ADD, R_T1, R_T1, R_T2, 1'b0);
          5'd23: u = mk(OP_SUB, R_T1, R_T1, R_X, 1'b0);
          5'd24: u = mk(OP_ADD, R_X, R_T0, R_ZERO, 1'b0);
          5'd25: u = mk(OP_ADD, R_Y, R_T1, R_ZERO, 1'b1);
          default: ;
        endcase
      end
    endcase
    return u;
  endfunction

  // CORDIC arctangent table, Q2.30
  function automatic logic signed [39:0] atan_val(logic [4:0] i);
    logic signed [39:0] v;
    case (i)
      5'd0:  v = 40'sd843314857;
      5'd1:  v = 40'sd497837829;
      5'd2:  v = 40'sd263043837;
      5'd3:  v = 40'sd133525159;
      5'd4:  v = 40'sd67021687;
      5'd5:  v = 40'sd33543516;
      5'd6:  v = 40'sd16775851;
      5'd7:  v = 40'sd8388437;
      5'd8:  v = 40'sd4194283;
      5'd9:  v = 40'sd2097149;
      default: v = 40'sd1 <<< (5'd30 - i);
    endcase
    return v;
  endfunction

  // Saturate a 33-bit sum to the state range
  function automatic logic signed [31:0] sat33(logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) r = v[32] ? S_MIN : S_MAX;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // Apply sign to a magnitude capped at 2^31
  function automatic logic signed [31:0] sign_sat(logic [31:0] m, logic neg);
    logic signed [31:0] r;
    if (neg) r = ~m + 32'd1;
    else r = m[31] ? S_MAX : m;
    return r;
  endfunction

  function automatic logic signed [31:0] coef_ext(logic signed [15:0] v);
    return {{3{v[15]}}, v, 13'b0};
  endfunction

endpackage

`default_nettype wire

### rtl/core/cmg_ctrl.sv
// ----------------------------------------------------------------------------
// cmg_ctrl - sequencer of the chaotic map generator
// Takes requests, keeps the result flag and steps the map micro-program.
// ----------------------------------------------------------------------------
`default_nettype none

module cmg_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_valid_i,
  output logic                  s_ready_o,
  output logic                  m_valid_o,
  input  wire                   m_ready_i,
  input  cmg_pkg::dp_status_t   status_i,
  output cmg_pkg::ctrl_cmd_t    cmd_o,
  output logic                  busy_o
);
  import cmg_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [4:0]  pc_q, pc_d;
  logic        ov_q, ov_d;
  logic        accept;
  uop_t        cur;

  assign cur       = prog_rom(status_i.active_map, pc_q);
  assign s_ready_o = (state_q == CS_IDLE) && (!ov_q || m_ready_i);
  assign accept    = s_valid_i && s_ready_o;
  assign m_valid_o = ov_q;

  // Next state
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    unique case (state_q)
      CS_IDLE: begin
        pc_d = 5'd0;
        if (accept && status_i.wrap) state_d = CS_FETCH;
      end
      CS_FETCH: state_d = CS_EXEC;
      CS_EXEC:  state_d = CS_WAIT;
      CS_WAIT: begin
        if (status_i.done) begin
          pc_d    = pc_q + 5'd1;
          state_d = cur.last ? CS_IDLE : CS_FETCH;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  // Result flag
  always_comb begin
    ov_d = ov_q;
    if (ov_q && m_ready_i) ov_d = 1'b0;
    if (accept) ov_d = 1'b1;
  end

  // Outputs
  always_comb begin
    cmd_o.item  = accept;
    cmd_o.fetch = (state_q == CS_FETCH);
    cmd_o.start = (state_q == CS_EXEC);
    cmd_o.uop   = cur;
    busy_o      = (state_q != CS_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      pc_q    <= 5'd0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      ov_q    <= ov_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/cmg_dp.sv
// ----------------------------------------------------------------------------
// cmg_dp - datapath of the chaotic map generator
// Config registers, latch clocks, point state, temporaries and the
// multi-cycle arithmetic unit (multiply, divide, root, CORDIC).
// ----------------------------------------------------------------------------
`default_nettype none

module cmg_dp (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  cmg_pkg::ctrl_cmd_t        cmd_i,
  output cmg_pkg::dp_status_t       status_o,
  input  wire                       cfg_we_i,
  input  wire  [2:0]                cfg_addr_i,
  input  wire  [31:0]               cfg_wdata_i,
  input  wire  [79:0]               item_i,
  output logic signed [31:0]        held_x_o,
  output logic signed [31:0]        held_y_o
);
  import cmg_pkg::*;

  // Configuration
  logic [2:0]         map_sel_q;
  logic               ext_clk_q;
  logic [31:0]        latch_stp_q, iter_stp_q;
  logic signed [15:0] trig_hi_q, trig_lo_q;

  // Tick state
  logic [31:0]        latch_ph_q, iter_ph_q;
  logic signed [31:0] x_q, y_q, hx_q, hy_q;
  logic               trig_q;
  logic [2:0]         active_q;
  logic signed [31:0] a_q, b_q, c_q, d_q;

  // Temporaries and operands
  logic signed [31:0] tmp_mem [TMP_N];
  logic signed [31:0] opa_q, opb_q;

  // Unit state
  unit_phase_e        phase_q, phase_d;
  logic [5:0]         cnt_q, cnt_d;
  logic               done_q, done_d;
  op_e                op_q, op_d;
  reg_e               dst_q, dst_d;
  logic               neg_q, neg_d;
  logic [63:0]        prod_q, prod_d;
  logic [55:0]        num_q, num_d, quo_q, quo_d;
  logic [31:0]        den_q, den_d;
  logic [32:0]        rem_q, rem_d;
  logic signed [39:0] z_q, z_d;
  logic signed [33:0] cx_q, cx_d, cy_q, cy_d;

  // Write-back
  logic               wb_en;
  reg_e               wb_dst;
  logic signed [31:0] wb_val;

  logic signed [15:0] lvl;
  logic [32:0]        latch_sum, iter_sum;
  logic               wrap;

  assign lvl       = item_i[79:64];
  assign latch_sum = {1'b0, latch_ph_q} + {1'b0, latch_stp_q};
  assign iter_sum  = {1'b0, iter_ph_q} + {1'b0, iter_stp_q};
  assign wrap      = iter_sum[32];

  assign status_o.wrap       = wrap;
  assign status_o.done       = done_q;
  assign status_o.unit_busy  = (phase_q != UP_IDLE);
  assign status_o.active_map = active_q;
  assign held_x_o = hx_q;
  assign held_y_o = hy_q;

  // Config write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_sel_q   <= 3'd0;
      ext_clk_q   <= 1'b0;
      latch_stp_q <= 32'd389566;
      iter_stp_q  <= 32'd389566;
      trig_hi_q   <= 16'sd2048;
      trig_lo_q   <= 16'sd0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_MAP_SEL:   map_sel_q   <= cfg_wdata_i[2:0];
        CFG_EXT_CLK:   ext_clk_q   <= cfg_wdata_i[0];
        CFG_LATCH_STP: latch_stp_q <= cfg_wdata_i;
        CFG_ITER_STP:  iter_stp_q  <= cfg_wdata_i;
        CFG_TRIG_HI:   trig_hi_q   <= cfg_wdata_i[15:0];
        CFG_TRIG_LO:   trig_lo_q   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Per-request latch clock, hold, rate accumulator and point write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_ph_q <= '0;
      iter_ph_q  <= '0;
      x_q        <= '0;
      y_q        <= '0;
      hx_q       <= '0;
      hy_q       <= '0;
      trig_q     <= 1'b0;
      active_q   <= 3'd0;
    end else if (cmd_i.item) begin
      logic gate;
      logic trig_n;
      gate   = 1'b0;
      trig_n = trig_q;
      if (ext_clk_q) begin
        if (trig_q) begin
          if (lvl <= trig_lo_q) trig_n = 1'b0;
        end else if (lvl >= trig_hi_q) begin
          trig_n = 1'b1;
          latch_ph_q <= '0;
        end
        gate   = trig_n;
        trig_q <= trig_n;
      end else begin
        gate = latch_sum[32];
        latch_ph_q <= latch_sum[32] ? 32'd0 : latch_sum[31:0];
      end
      if (gate) begin
        hx_q <= x_q;
        hy_q <= y_q;
      end
      iter_ph_q <= wrap ? 32'd0 : iter_sum[31:0];
      if (wrap && (active_q != map_sel_q)) begin
        x_q      <= '0;
        y_q      <= '0;
        active_q <= map_sel_q;
      end
    end else if (wb_en) begin
      if (wb_dst == R_X) x_q <= wb_val;
      if (wb_dst == R_Y) y_q <= wb_val;
    end
  end

  // Coefficients of the current request
  always_ff @(posedge clk_i) begin
    if (cmd_i.item) begin
      a_q <= coef_ext(item_i[15:0]);
      b_q <= coef_ext(item_i[31:16]);
      c_q <= coef_ext(item_i[47:32]);
      d_q <= coef_ext(item_i[63:48]);
    end
  end

  // Operand source select
  function automatic logic signed [31:0] fixed_src(reg_e s, logic signed [31:0] xv,
      logic signed [31:0] yv, logic signed [31:0] av, logic signed [31:0] bv,
      logic signed [31:0] cv, logic signed [31:0] dv);
    logic signed [31:0] r;
    case (s)
      R_X:     r = xv;
      R_Y:     r = yv;
      R_A:     r = av;
      R_B:     r = bv;
      R_C:     r = cv;
      R_D:     r = dv;
      R_ONE:   r = S_ONE;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Temporary store and registered operand read
  always_ff @(posedge clk_i) begin
    if (wb_en && wb_dst[3]) tmp_mem[wb_dst[2:0]] <= wb_val;
    if (cmd_i.fetch) begin
      opa_q <= cmd_i.uop.sa[3] ? tmp_mem[cmd_i.uop.sa[2:0]]
                               : fixed_src(cmd_i.uop.sa, x_q, y_q, a_q, b_q, c_q, d_q);
      opb_q <= cmd_i.uop.sb[3] ? tmp_mem[cmd_i.uop.sb[2:0]]
                               : fixed_src(cmd_i.uop.sb, x_q, y_q, a_q, b_q, c_q, d_q);
    end
  end

  // Arithmetic unit
  logic signed [32:0] add33, sub33;
  logic [31:0]        ma, mb;
  logic [63:0]        prod_full;
  logic [39:0]        mul_hi;
  logic [32:0]        dtrial, strial, sr2;
  logic               dge, sge;
  logic signed [39:0] twok, z0;
  logic signed [33:0] cdx, cdy, cv, cvn, csh;
  logic [31:0]        qcap, mcap, sq_u;

  assign add33     = {opa_q[31], opa_q} + {opb_q[31], opb_q};
  assign sub33     = {opa_q[31], opa_q} - {opb_q[31], opb_q};
  assign ma        = mag32(opa_q);
  assign mb        = mag32(opb_q);
  assign prod_full = ma * mb;
  assign mul_hi    = prod_q[63:24];
  assign mcap      = (|mul_hi[39:31]) ? 32'h8000_0000 : mul_hi[31:0];
  assign dtrial    = {rem_q[31:0], num_q[55]};
  assign dge       = dtrial >= {1'b0, den_q};
  assign sr2       = {rem_q[30:0], num_q[55:54]};
  assign strial    = {3'b0, quo_q[27:0], 2'b01};
  assign sge       = sr2 >= strial;
  assign qcap      = (quo_q > 56'd2147483648) ? 32'h8000_0000 : quo_q[31:0];
  assign sq_u      = opa_q[31] ? ((opa_q == S_MIN) ? S_MAX : -opa_q) : opa_q;
  assign twok      = TWO_PI30 <<< cnt_q[2:0];
  assign z0        = {{2{opa_q[31]}}, opa_q, 6'b0};
  assign cdx       = cy_q >>> cnt_q[4:0];
  assign cdy       = cx_q >>> cnt_q[4:0];
  assign cv        = (op_q == OP_SIN) ? cy_q : cx_q;
  assign cvn       = neg_q ? -cv : cv;
  assign csh       = cvn >>> 6;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    op_d    = op_q;
    dst_d   = dst_q;
    neg_d   = neg_q;
    prod_d  = prod_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    z_d     = z_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    wb_en   = 1'b0;
    wb_dst  = dst_q;
    wb_val  = '0;
    unique case (phase_q)
      UP_IDLE: begin
        if (cmd_i.start) begin
          op_d   = cmd_i.uop.op;
          dst_d  = cmd_i.uop.dst;
          wb_dst = cmd_i.uop.dst;
          neg_d  = opa_q[31] ^ opb_q[31];
          case (cmd_i.uop.op)
            OP_ADD: begin
              wb_en = 1'b1; wb_val = sat33(add33); done_d = 1'b1;
            end
            OP_SUB: begin
              wb_en = 1'b1; wb_val = sat33(sub33); done_d = 1'b1;
            end
            OP_CADD: begin
              wb_en = 1'b1; wb_val = sat33(x_q[31] ? sub33 : add33); done_d = 1'b1;
            end
            OP_MUL: begin
              prod_d  = prod_full;
              phase_d = UP_MUL;
            end
            OP_DIV: begin
              if (opb_q == '0) begin
                wb_en = 1'b1; wb_val = opa_q[31] ? S_MIN : S_MAX; done_d = 1'b1;
              end else begin
                num_d   = {ma, 24'b0};
                den_d   = mb;
                rem_d   = '0;
                quo_d   = '0;
                cnt_d   = 6'd55;
                phase_d = UP_DIV;
              end
            end
            OP_SQRT: begin
              num_d   = {sq_u, 24'b0};
              rem_d   = '0;
              quo_d   = '0;
              cnt_d   = 6'd27;
              phase_d = UP_SQRT;
            end
            default: begin // sine or cosine
              z_d     = opa_q[31] ? z0 + (TWO_PI30 <<< 5) : z0;
              cnt_d   = 6'd4;
              phase_d = UP_RED;
            end
          endcase
        end
      end
      UP_MUL: begin
        wb_en = 1'b1; wb_val = sign_sat(mcap, neg_q); done_d = 1'b1;
        phase_d = UP_IDLE;
      end
      // restoring divide, one quotient bit a cycle
      UP_DIV: begin
        rem_d = dge ? dtrial - {1'b0, den_q} : dtrial;
        quo_d = {quo_q[54:0], dge};
        num_d = num_q << 1;
        if (cnt_q == 6'd0) phase_d = UP_DIVOUT;
        else cnt_d = cnt_q - 6'd1;
      end
      UP_DIVOUT: begin
        wb_en = 1'b1; wb_val = sign_sat(qcap, neg_q); done_d = 1'b1;
        phase_d = UP_IDLE;
      end
      // restoring square root, one root bit a cycle
      UP_SQRT: begin
        rem_d = sge ? sr2 - strial : sr2;
        quo_d = {quo_q[54:0], sge};
        num_d = num_q << 2;
        if (cnt_q == 6'd0) begin
          wb_en = 1'b1; wb_val = {4'b0, quo_d[27:0]}; done_d = 1'b1;
          phase_d = UP_IDLE;
        end else cnt_d = cnt_q - 6'd1;
      end
      // angle mod 2*pi by binary subtraction
      UP_RED: begin
        if (z_q >= twok) z_d = z_q - twok;
        if (cnt_q == 6'd0) phase_d = UP_FOLD1;
        else cnt_d = cnt_q - 6'd1;
      end
      UP_FOLD1: begin
        if (z_q > PI30) z_d = z_q - TWO_PI30;
        phase_d = UP_FOLD2;
      end
      UP_FOLD2: begin
        neg_d = 1'b0;
        if (z_q > HALF_PI30) begin
          z_d = z_q - PI30; neg_d = 1'b1;
        end else if (z_q < -HALF_PI30) begin
          z_d = z_q + PI30; neg_d = 1'b1;
        end
        cx_d    = CORDIC_K;
        cy_d    = '0;
        cnt_d   = 6'd0;
        phase_d = UP_ROT;
      end
      UP_ROT: begin
        if (!z_q[39]) begin
          cx_d = cx_q - cdx; cy_d = cy_q + cdy; z_d = z_q - atan_val(cnt_q[4:0]);
        end else begin
          cx_d = cx_q + cdx; cy_d = cy_q - cdy; z_d = z_q + atan_val(cnt_q[4:0]);
        end
        if (cnt_q == 6'd29) phase_d = UP_CFIN;
        else cnt_d = cnt_q + 6'd1;
      end
      UP_CFIN: begin
        wb_en = 1'b1; wb_val = csh[31:0]; done_d = 1'b1;
        phase_d = UP_IDLE;
      end
      default: phase_d = UP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= UP_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    dst_q  <= dst_d;
    neg_q  <= neg_d;
    prod_q <= prod_d;
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    z_q    <= z_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
  end

endmodule

`default_nettype wire

### rtl/core/chaotic_map_generator_top.sv
// ----------------------------------------------------------------------------
// chaotic_map_generator_top - strange-attractor point generator
// Channel   Dir  Payload (low bits first)
// s_axis    in   coef_a, coef_b, coef_c, coef_d, clock_level (16 bits each)
// m_axis    out  x_out, y_out (32 bits each)
// cfg       in   write enable, register index, 32-bit data
//
// Each request returns one result (the held point) right after acceptance.
// Without an iteration tick the next request is accepted once the result is taken.
// On an iteration tick the map micro-program runs, one op at a time through the
// shared arithmetic unit, and no request is accepted until the program ends.
// Reset is asynchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module chaotic_map_generator_top (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  wire  [79:0]  s_axis_tdata_i,  // coef_a, coef_b, coef_c, coef_d, clock_level
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  output logic [63:0]  m_axis_tdata_o,  // x_out, y_out
  input  wire          cfg_we_i,
  input  wire  [2:0]   cfg_addr_i,
  input  wire  [31:0]  cfg_wdata_i
);
  import cmg_pkg::*;

  ctrl_cmd_t          cmd;
  dp_status_t         status;
  logic               busy;
  logic signed [31:0] held_x, held_y;

  // Sequencer
  cmg_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .status_i  (status),
    .cmd_o     (cmd),
    .busy_o    (busy)
  );

  // Datapath
  cmg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (s_axis_tdata_i),
    .held_x_o    (held_x),
    .held_y_o    (held_y)
  );

  assign m_axis_tdata_o = {held_y, held_x};

`ifndef ASSERT_OFF
  // unit completes only while a program is running
  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.done |-> busy) else $error("unit done outside program");

  // a request always leaves a result waiting
  a_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> m_axis_tvalid_o)
    else $error("request without result");

  // no new operation while the unit is still working
  a_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |-> !status.unit_busy) else $error("start while unit busy");
`endif

endmodule

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench for chaotic_map_generator_top
// Drives sample-tick requests with random gaps and random output stalls,
// predicts the held point with a bit-exact fixed-point model of the eight
// maps, and compares every result field by field in order of arrival.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import cmg_pkg::*;

  localparam int      SETTLE_CYCLES = 600;
  localparam int      STALL_LIMIT   = 20000;
  localparam longint  SAT_HI        = 64'sd2147483647;
  localparam longint  SAT_LO        = -64'sd2147483648;
  localparam longint  Q_ONE         = 64'sd16777216;
  localparam longint  ANG_TWO_PI    = 64'sd6746518852;
  localparam longint  ANG_PI        = 64'sd3373259426;
  localparam longint  ANG_HALF_PI   = 64'sd1686629713;
  localparam longint  ANG_GAIN      = 64'sd652032874;

  typedef struct {
    logic signed [15:0] a, b, c, d, lvl;
  } tick_t;

  typedef struct {
    logic [31:0] x, y;
  } point_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [79:0] s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [63:0] m_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_data = '0;

  chaotic_map_generator_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Shadow registers and model state
  logic [2:0]         sh_map;
  logic               sh_ext;
  logic [31:0]        sh_lstep, sh_istep;
  logic signed [15:0] sh_thi, sh_tlo;
  longint unsigned    lat_ph, itr_ph;
  longint             pt_x, pt_y, hold_x, hold_y;
  logic               trig_q;
  logic [2:0]         cur_map;

  point_t held_q[$];
  bit     failed = 1'b0;
  bit     hold_off_req = 1'b0;
  longint atan_q30 [30] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2};

  // ---------------- fixed-point arithmetic ----------------
  function automatic longint clamp(longint v);
    return v > SAT_HI ? SAT_HI : (v < SAT_LO ? SAT_LO : v);
  endfunction

  function automatic longint q_add(longint a, longint b);
    return clamp(a + b);
  endfunction

  function automatic longint q_sub(longint a, longint b);
    return clamp(a - b);
  endfunction

  function automatic longint unsigned absval(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint q_mul(longint a, longint b);
    bit neg;
    longint unsigned r;
    neg = (a < 0) != (b < 0);
    r = (absval(a) * absval(b)) >> 24;
    if (r > 64'd2147483648) r = 64'd2147483648;
    return clamp(neg ? -longint'(r) : longint'(r));
  endfunction

  function automatic longint q_div(longint n, longint d);
    longint unsigned un, ud, rem, q, bitv;
    bit neg;
    un = absval(n); ud = absval(d); rem = 0; q = 0;
    neg = (n < 0) != (d < 0);
    if (d == 0) return n < 0 ? SAT_LO : SAT_HI;
    for (int k = 55; k >= 0; k--) begin
      bitv = k >= 24 ? (un >> (k - 24)) & 1 : 0;
      rem = (rem << 1) | bitv;
      q = q << 1;
      if (rem >= ud) begin
        rem = rem - ud;
        q = q | 1;
      end
      if (q > 64'd2147483648) begin
        q = 64'd2147483648;
        break;
      end
    end
    return clamp(neg ? -longint'(q) : longint'(q));
  endfunction

  // Floored root of the saturated magnitude
  function automatic longint q_root(longint v);
    longint unsigned u, root, rem, b1, b0, trial;
    int hb, lb;
    u = v < 0 ? clamp(-v) : v; root = 0; rem = 0;
    for (int k = 27; k >= 0; k--) begin
      hb = 2 * k + 1; lb = 2 * k;
      b1 = hb >= 24 ? (u >> (hb - 24)) & 1 : 0;
      b0 = lb >= 24 ? (u >> (lb - 24)) & 1 : 0;
      rem = (rem << 2) | (b1 << 1) | b0;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return clamp(longint'(root));
  endfunction

  // CORDIC rotation in Q2.30 after folding into +-pi/2
  function automatic void q_sincos(input longint ang, output longint s, output longint c);
    longint r, x, y, dx, dy;
    bit neg;
    r = (ang * 64) % ANG_TWO_PI;
    x = ANG_GAIN; y = 0; neg = 1'b0;
    if (r < 0) r += ANG_TWO_PI;
    if (r > ANG_PI) r -= ANG_TWO_PI;
    if (r > ANG_HALF_PI) begin
      r -= ANG_PI; neg = 1'b1;
    end else if (r < -ANG_HALF_PI) begin
      r += ANG_PI; neg = 1'b1;
    end
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (r >= 0) begin
        x -= dx; y += dy; r -= atan_q30[i];
      end else begin
        x += dx; y -= dy; r += atan_q30[i];
      end
    end
    if (neg) begin
      x = -x; y = -y;
    end
    s = clamp(y >>> 6);
    c = clamp(x >>> 6);
  endfunction

  function automatic longint q_sin(longint a);
    longint s, c;
    q_sincos(a, s, c);
    return s;
  endfunction

  function automatic longint q_cos(longint a);
    longint s, c;
    q_sincos(a, s, c);
    return c;
  endfunction

  // Gumowski-Mira shaping term
  function automatic longint gm_term(longint x, longint mu);
    longint x2, s, num;
    x2 = q_mul(x, x);
    s = q_sub(Q_ONE, mu);
    num = q_mul(q_add(s, s), x2);
    return q_add(q_mul(mu, x), q_div(num, q_add(Q_ONE, x2)));
  endfunction

  function automatic void step_point(longint a, longint b, longint c, longint d);
    longint x, y, nx, ny, t;
    x = pt_x; y = pt_y;
    case (cur_map)
      3'd0: begin
        nx = q_add(q_sin(q_mul(a, y)), q_mul(c, q_cos(q_mul(a, x))));
        ny = q_add(q_sin(q_mul(b, x)), q_mul(d, q_cos(q_mul(b, y))));
      end
      3'd1: begin
        nx = q_sub(q_sin(q_mul(a, y)), q_cos(q_mul(b, x)));
        ny = q_sub(q_sin(q_mul(c, x)), q_cos(q_mul(d, y)));
      end
      3'd2: begin
        nx = q_sub(q_mul(d, q_sin(q_mul(a, x))), q_sin(q_mul(b, y)));
        ny = q_add(q_mul(c, q_cos(q_mul(a, x))), q_cos(q_mul(b, y)));
      end
      3'd3: begin
        nx = q_add(q_mul(q_sin(q_div(q_mul(x, y), b)), y), q_cos(q_sub(q_mul(a, x), y)));
        ny = q_add(x, q_div(q_sin(y), b));
      end
      3'd4: begin
        nx = q_add(q_sin(q_mul(y, b)), q_mul(c, q_sin(q_mul(x, b))));
        ny = q_add(q_sin(q_mul(x, a)), q_mul(d, q_sin(q_mul(y, a))));
      end
      3'd5: begin
        t = q_root(q_sub(q_mul(b, x), c));
        nx = q_add(y, x >= 0 ? t : -t);
        ny = q_sub(a, x);
      end
      3'd6: begin
        t = q_root(q_sub(q_sub(q_mul(b, x), Q_ONE), c));
        nx = q_add(q_sub(y, Q_ONE), x >= 0 ? t : -t);
        ny = q_sub(q_sub(a, x), Q_ONE);
      end
      default: begin
        t = q_mul(q_mul(a, q_sub(Q_ONE, q_mul(b, q_mul(y, y)))), y);
        nx = q_add(q_add(y, t), gm_term(x, c));
        ny = q_add(-x, gm_term(nx, c));
      end
    endcase
    pt_x = nx;
    pt_y = ny;
  endfunction

  // One sample tick: latch, then maybe iterate; queues the held point
  function automatic void predict_tick(tick_t t);
    longint unsigned sum;
    bit gate;
    point_t p;
    gate = 1'b0;
    if (sh_ext) begin
      if (trig_q) begin
        if (t.lvl <= sh_tlo) trig_q = 1'b0;
      end else if (t.lvl >= sh_thi) begin
        trig_q = 1'b1;
        lat_ph = 0;
      end
      gate = trig_q;
    end else begin
      sum = lat_ph + sh_lstep;
      if (sum > 64'hffff_ffff) begin
        lat_ph = 0; gate = 1'b1;
      end else begin
        lat_ph = sum;
      end
    end
    if (gate) begin
      hold_x = pt_x; hold_y = pt_y;
    end
    p.x = hold_x[31:0];
    p.y = hold_y[31:0];
    held_q.push_back(p);
    sum = itr_ph + sh_istep;
    if (sum > 64'hffff_ffff) begin
      itr_ph = 0;
      if (cur_map != sh_map) begin
        pt_x = 0; pt_y = 0; cur_map = sh_map;
      end
      step_point(longint'(t.a) * 8192, longint'(t.b) * 8192,
                 longint'(t.c) * 8192, longint'(t.d) * 8192);
    end else begin
      itr_ph = sum;
    end
  endfunction

  // ---------------- result checker ----------------
  always @(posedge clk_i) begin
    point_t e;
    if (m_valid && m_ready) begin
      if (held_q.size() == 0) begin
        $error("unexpected result x=%h y=%h", m_data[31:0], m_data[63:32]);
        failed = 1'b1;
      end else begin
        e = held_q.pop_front();
        if (m_data[31:0] !== e.x) begin
          $error("x_out expected %h actual %h", e.x, m_data[31:0]);
          failed = 1'b1;
        end
        if (m_data[63:32] !== e.y) begin
          $error("y_out expected %h actual %h", e.y, m_data[63:32]);
          failed = 1'b1;
        end
      end
    end
  end

  // Stall watchdog
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Output ready: random stalls, plus a long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_ready <= 1'b0;
        hold_off_req = 1'b0;
        repeat (400) @(negedge clk_i);
      end else if ($urandom_range(0, 9) < 6) begin
        m_ready <= 1'b1;
        n = $urandom_range(0, 9) < 3 ? $urandom_range(20, 60) : $urandom_range(0, 8);
        repeat (n) @(negedge clk_i);
      end else begin
        m_ready <= 1'b0;
        n = $urandom_range(0, 19) == 0 ? $urandom_range(30, 80) : $urandom_range(0, 3);
        repeat (n) @(negedge clk_i);
      end
    end
  end

  // ---------------- stimulus helpers ----------------
  function automatic logic signed [15:0] rand_coef();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) return 16'($signed($urandom_range(0, 8191)) - 4096);
    if (k < 8) return 16'($urandom);
    case ($urandom_range(0, 4))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return 16'sd2048;
      default: return -16'sd2048;
    endcase
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    t.a = rand_coef(); t.b = rand_coef(); t.c = rand_coef(); t.d = rand_coef();
    t.lvl = 16'($urandom);
    return t;
  endfunction

  function automatic int rand_gap();
    return $urandom_range(0, 19) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 2);
  endfunction

  // Sends one request after a gap and predicts on acceptance
  task automatic send_tick(tick_t t, int gap);
    repeat (gap) begin
      @(negedge clk_i);
      s_valid <= 1'b0;
    end
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_data <= {t.lvl, t.d, t.c, t.b, t.a};
    do @(posedge clk_i); while (!s_ready);
    predict_tick(t);
  endtask

  // Drop valid and wait until the block has gone quiet
  task automatic settle();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (held_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] v);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= v;
    case (idx)
      CFG_MAP_SEL:   sh_map = v[2:0];
      CFG_EXT_CLK:   sh_ext = v[0];
      CFG_LATCH_STP: sh_lstep = v;
      CFG_ITER_STP:  sh_istep = v;
      CFG_TRIG_HI:   sh_thi = v[15:0];
      CFG_TRIG_LO:   sh_tlo = v[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // ---------------- tests ----------------
  // Extremes of every field through each map, with a map change on all but the first
  task automatic test_directed();
    tick_t t;
    settle();
    cfg_write(CFG_LATCH_STP, 32'hffff_ffff);
    cfg_write(CFG_ITER_STP, 32'h8000_0000);
    for (int m = 0; m < 8; m++) begin
      settle();
      cfg_write(CFG_MAP_SEL, m);
      t = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
      send_tick(t, 0);
      t = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
      send_tick(t, 0);
      // zero divisor and zero coefficients
      t = '{16'sd2048, 16'sd0, -16'sd1024, 16'sd0, 16'sd0};
      send_tick(t, 1);
    end
  endtask

  // Random coefficients through each map with fast, varied rates
  task automatic test_maps();
    for (int m = 0; m < 8; m++) begin
      settle();
      cfg_write(CFG_MAP_SEL, m);
      cfg_write(CFG_EXT_CLK, 0);
      cfg_write(CFG_ITER_STP, $urandom_range(32'h4000_0000, 32'hffff_ffff));
      cfg_write(CFG_LATCH_STP, $urandom_range(32'h2000_0000, 32'hffff_ffff));
      repeat (70) send_tick(rand_tick(), rand_gap());
    end
  endtask

  // Schmitt-triggered latch, normal, inverted and extreme thresholds
  task automatic test_external();
    tick_t t;
    logic signed [15:0] hi_v [3] = '{16'sd2048, -16'sd1000, 16'sh7fff};
    logic signed [15:0] lo_v [3] = '{16'sd0, 16'sd3000, 16'sh8000};
    settle();
    cfg_write(CFG_EXT_CLK, 1);
    cfg_write(CFG_MAP_SEL, 0);
    cfg_write(CFG_ITER_STP, 32'hc000_0000);
    for (int p = 0; p < 3; p++) begin
      settle();
      cfg_write(CFG_TRIG_HI, 32'(hi_v[p]));
      cfg_write(CFG_TRIG_LO, 32'(lo_v[p]));
      repeat (50) begin
        t = rand_tick();
        case ($urandom_range(0, 3))
          0: t.lvl = hi_v[p];
          1: t.lvl = lo_v[p];
          2: t.lvl = 16'($signed($urandom_range(0, 8191)) - 3072);
          default: ;
        endcase
        send_tick(t, rand_gap());
      end
    end
    settle();
    cfg_write(CFG_EXT_CLK, 0);
  endtask

  // Long receiver hold-off while requests keep coming
  task automatic test_backpressure();
    settle();
    cfg_write(CFG_MAP_SEL, 5);
    cfg_write(CFG_ITER_STP, 32'hffff_ffff);
    cfg_write(CFG_LATCH_STP, 32'h9000_0000);
    hold_off_req = 1'b1;
    repeat (60) send_tick(rand_tick(), 0);
  endtask

  // Random register settings, steps at the extremes included
  task automatic test_random_cfg();
    logic [31:0] steps [4] = '{32'd0, 32'hffff_ffff, 32'd389566, 32'h8000_0000};
    for (int p = 0; p < 8; p++) begin
      settle();
      cfg_write(CFG_MAP_SEL, $urandom_range(0, 7));
      cfg_write(CFG_EXT_CLK, $urandom_range(0, 1));
      cfg_write(CFG_LATCH_STP, p < 4 ? steps[p] : $urandom);
      cfg_write(CFG_ITER_STP, p < 4 ? steps[3 - p] : $urandom);
      cfg_write(CFG_TRIG_HI, $urandom);
      cfg_write(CFG_TRIG_LO, $urandom);
      repeat (20) send_tick(rand_tick(), rand_gap());
    end
  endtask

  // ---------------- main sequence ----------------
  initial begin
    sh_map = 0; sh_ext = 0; sh_lstep = 32'd389566; sh_istep = 32'd389566;
    sh_thi = 16'sd2048; sh_tlo = 16'sd0;
    lat_ph = 0; itr_ph = 0; pt_x = 0; pt_y = 0; hold_x = 0; hold_y = 0;
    trig_q = 1'b0; cur_map = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_maps();
    test_external();
    test_backpressure();
    test_random_cfg();

    @(negedge clk_i);
    s_valid <= 1'b0;
    while (held_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
